// ----- design/pidw_pkg.sv -----
`timescale 1ns / 1ps

package pidw_pkg;

  // Default values for the top-level parameters.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int GAIN_W   = 32;
  localparam int VALUE_W  = 32;
  localparam int BAND_W   = 31;
  localparam int ILIM_W   = 31;
  localparam int OLIM_W   = 30;
  localparam int MODE_W   = 2;

  // A scaled product term saturates at plus or minus 2^CAP_LOG2.
  localparam int CAP_LOG2 = 61;
  localparam int TERM_W   = CAP_LOG2 + 2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_BAND   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_LIMIT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_MODE    = 3'd6;

  // Loop modes. The unused code behaves as the plain mode.
  localparam logic [MODE_W-1:0] MODE_CLAMP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRAP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd2;

endpackage

// ----- design/pidw_mul.sv -----
`timescale 1ns / 1ps

// Registered gain multiply, then a floor shift by the fraction bits and a
// saturation of the scaled term at plus or minus 2^CAP_LOG2.
module pidw_mul
  import pidw_pkg::*;
#(
  parameter int XW        = DATA_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [GAIN_W-1:0] gain,
  input  logic signed [XW-1:0]     x,
  output logic signed [TERM_W-1:0] term
);

  localparam int PW = GAIN_W + XW;
  localparam int CW = (PW > 64) ? PW : 64;
  localparam logic signed [CW-1:0] CAP_POS =
    {{(CW-CAP_LOG2-1){1'b0}}, 1'b1, {CAP_LOG2{1'b0}}};
  localparam logic signed [CW-1:0] CAP_NEG = -CAP_POS;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shifted;
  logic signed [CW-1:0] shx;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(gain) * PW'(x);
    end
  end

  // Arithmetic shift rounds toward minus infinity.
  assign shifted = prod >>> FRAC_BITS;
  assign shx     = CW'(shifted);

  always_comb begin
    if (shx > CAP_POS) begin
      term = TERM_W'(CAP_POS);
    end else if (shx < CAP_NEG) begin
      term = TERM_W'(CAP_NEG);
    end else begin
      term = TERM_W'(shx);
    end
  end

endmodule

// ----- design/pid_stage_with_wrap_and_limits.sv -----
`timescale 1ns / 1ps
// PID stage: throughput is one beat per cycle when the output is not stalled.
// The eight-stage pipeline is paced only by the output handshake.
// Reset (rst, synchronous, active high) empties the pipeline, zeroes the
// previous error, the integral and the configuration; data registers are not reset.

module pid_stage_with_wrap_and_limits
  import pidw_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream: tdata = setpoint [31:0], measured [63:32].
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [2*VALUE_W-1:0]   s_axis_tdata,
  // Output stream: tdata = drive [31:0].
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [VALUE_W-1:0]     m_axis_tdata,
  // tuser = drive_saturated [0], integ_active [1].
  output logic [1:0]             m_axis_tuser,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]      cfg_data
);

  // Number of pipeline stages; stage NST-1 is the output register.
  localparam int NST = 8;
  // Working width of the raw error: the setpoint clamp, the difference and
  // the angle fold all stay well inside this.
  localparam int EW  = VALUE_W + 3;
  localparam int DW  = DATA_WIDTH;

  localparam logic signed [63:0] EMAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam logic signed [63:0] EMIN = -EMAX - 64'sd1;
  localparam logic signed [EW-1:0] ONE = EW'(64'sd1 <<< FRAC_BITS);

  // Configuration registers. Writes must arrive only while the pipeline is idle (the user's duty;
  // the block itself does not enforce it), so every stage can read them directly.
  logic signed [GAIN_W-1:0] prop_gain;
  logic signed [GAIN_W-1:0] integ_gain;
  logic signed [GAIN_W-1:0] deriv_gain;
  logic [BAND_W-1:0]        error_band;
  logic [ILIM_W-1:0]        integ_limit;
  logic [OLIM_W-1:0]        output_limit;
  logic [MODE_W-1:0]        loop_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= '0;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      error_band   <= '0;
      integ_limit  <= '0;
      output_limit <= '0;
      loop_mode    <= MODE_CLAMP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP_GAIN:    prop_gain    <= cfg_data;
        REG_INTEG_GAIN:   integ_gain   <= cfg_data;
        REG_DERIV_GAIN:   deriv_gain   <= cfg_data;
        REG_ERROR_BAND:   error_band   <= cfg_data[BAND_W-1:0];
        REG_INTEG_LIMIT:  integ_limit  <= cfg_data[ILIM_W-1:0];
        REG_OUTPUT_LIMIT: output_limit <= cfg_data[OLIM_W-1:0];
        REG_LOOP_MODE:    loop_mode    <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control. Each stage has a valid bit; a stage takes a new beat
  // whenever it is empty or the stage after it is moving, so bubbles close
  // up and the input keeps flowing while a result waits at the output, until every stage is full.
  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = m_axis_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];

  // Stage 0: input register.
  logic signed [VALUE_W-1:0] sp0;
  logic signed [VALUE_W-1:0] ms0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sp0 <= s_axis_tdata[VALUE_W-1:0];
      ms0 <= s_axis_tdata[2*VALUE_W-1:VALUE_W];
    end
  end

  // Stage 1: setpoint clamp (clamp mode) and the raw difference. A setpoint
  // beyond the output limit is pulled one unit inside it; one that sits
  // exactly on the limit passes unchanged.
  logic signed [EW-1:0] omx;
  logic signed [EW-1:0] goal;
  logic signed [EW-1:0] eraw_next;
  logic signed [EW-1:0] eraw1;

  assign omx = EW'({1'b0, output_limit});

  always_comb begin
    goal = EW'(sp0);
    if (loop_mode == MODE_CLAMP) begin
      if (goal > omx) begin
        goal = omx - ONE;
      end else if (goal < -omx) begin
        goal = -omx + ONE;
      end
    end
    eraw_next = goal - EW'(ms0);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      eraw1 <= eraw_next;
    end
  end

  // Stage 2: angle fold (wrap mode) and saturation to the data width. The
  // period of the fold is twice the output limit; the error takes the
  // shorter way round and is folded at most once. The saturated error also
  // becomes the previous error for the next beat.
  logic signed [EW-1:0] wrap_w;
  logic signed [EW-1:0] ewrap;
  logic signed [63:0]   ewide;
  logic signed [DW-1:0] e_next;
  logic signed [DW-1:0] prev_error;
  logic signed [DW-1:0] e2;
  logic signed [DW-1:0] ep2;

  assign wrap_w = omx <<< 1;

  always_comb begin
    ewrap = eraw1;
    if (loop_mode == MODE_WRAP) begin
      if (eraw1 > 0 && (wrap_w - eraw1) < eraw1) begin
        ewrap = eraw1 - wrap_w;
      end else if (eraw1 < 0 && (wrap_w + eraw1) < -eraw1) begin
        ewrap = eraw1 + wrap_w;
      end
    end
    ewide = 64'(ewrap);
    if (ewide > EMAX) begin
      e_next = DW'(EMAX);
    end else if (ewide < EMIN) begin
      e_next = DW'(EMIN);
    end else begin
      e_next = DW'(ewide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
    end else if (v[1] && rdy[2]) begin
      prev_error <= e_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      e2  <= e_next;
      ep2 <= prev_error;
    end
  end

  // Stage 3: change of error and the integration band test.
  logic signed [DW-1:0] e3;
  logic signed [DW:0]   de3;
  logic                 act3;
  logic signed [63:0]   bandx;
  logic signed [63:0]   e2x;

  assign bandx = 64'({1'b0, error_band});
  assign e2x   = 64'(e2);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      e3   <= e2;
      de3  <= (DW+1)'(e2) - (DW+1)'(ep2);
      act3 <= (e2x < bandx) && (e2x > -bandx);
    end
  end

  // Stage 4: the three gain products, registered inside the multipliers.
  logic signed [TERM_W-1:0] p_term;
  logic signed [TERM_W-1:0] i_term;
  logic signed [TERM_W-1:0] d_term;
  logic                     act4;

  pidw_mul #(.XW(DW), .FRAC_BITS(FRAC_BITS)) u_mul_p (
    .clk  (clk),
    .en   (rdy[4]),
    .gain (prop_gain),
    .x    (e3),
    .term (p_term)
  );

  pidw_mul #(.XW(DW), .FRAC_BITS(FRAC_BITS)) u_mul_i (
    .clk  (clk),
    .en   (rdy[4]),
    .gain (integ_gain),
    .x    (e3),
    .term (i_term)
  );

  pidw_mul #(.XW(DW + 1), .FRAC_BITS(FRAC_BITS)) u_mul_d (
    .clk  (clk),
    .en   (rdy[4]),
    .gain (deriv_gain),
    .x    (de3),
    .term (d_term)
  );

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      act4 <= act3;
    end
  end

  // Stage 5: scaled terms; the proportional and derivative parts are summed
  // here so that the integral stage has a single add behind it.
  logic signed [63:0]       pd5;
  logic signed [TERM_W-1:0] ki5;
  logic                     act5;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      pd5  <= 64'(p_term) + 64'(d_term);
      ki5  <= i_term;
      act5 <= act4;
    end
  end

  // Stage 6: integral update. Inside the band an integral beyond the limit
  // is pulled back to it; otherwise the scaled error is added and the
  // sum saturates to the data width. Outside the band it is cleared. The
  // integral register is both the loop state and this stage's payload.
  logic signed [DW-1:0] integral_sum;
  logic signed [DW-1:0] integ_next;
  logic signed [63:0]   intx;
  logic signed [63:0]   limx;
  logic signed [63:0]   isum;
  logic signed [63:0]   pd6;
  logic                 act6;

  assign intx = 64'(integral_sum);
  assign limx = 64'({1'b0, integ_limit});
  assign isum = intx + 64'(ki5);

  always_comb begin
    if (!act5) begin
      integ_next = '0;
    end else if (intx < -limx) begin
      integ_next = DW'(-limx);
    end else if (intx > limx) begin
      integ_next = DW'(limx);
    end else if (isum > EMAX) begin
      integ_next = DW'(EMAX);
    end else if (isum < EMIN) begin
      integ_next = DW'(EMIN);
    end else begin
      integ_next = DW'(isum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
    end else if (v[5] && rdy[6]) begin
      integral_sum <= integ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      pd6  <= pd5;
      act6 <= act5;
    end
  end

  // Stage 7: output register. The total is clamped to the output limit.
  localparam int SW = 65;
  logic signed [SW-1:0]      total;
  logic signed [SW-1:0]      olim;
  logic signed [VALUE_W-1:0] drive_next;
  logic                      sat_next;
  logic signed [VALUE_W-1:0] drive7;
  logic                      sat7;
  logic                      act7;

  assign total = SW'(pd6) + SW'(integral_sum);
  assign olim  = SW'({1'b0, output_limit});

  always_comb begin
    if (total > olim) begin
      drive_next = VALUE_W'(olim);
      sat_next   = 1'b1;
    end else if (total < -olim) begin
      drive_next = VALUE_W'(-olim);
      sat_next   = 1'b1;
    end else begin
      drive_next = VALUE_W'(total);
      sat_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      drive7 <= drive_next;
      sat7   <= sat_next;
      act7   <= act6;
    end
  end

  assign m_axis_tvalid = v[NST-1];
  assign m_axis_tdata  = drive7;
  assign m_axis_tuser  = {act7, sat7};

endmodule

// ----- design/pidw_checker.sv -----
`timescale 1ns / 1ps

module pidw_checker
  import pidw_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [2*VALUE_W-1:0]   s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [VALUE_W-1:0]     m_axis_tdata,
  input logic [1:0]             m_axis_tuser,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [GAIN_W-1:0]      cfg_data
);

  logic [OLIM_W-1:0]  om_shadow;
  logic [3:0]         inflight;
  logic               in_beat;
  logic               out_beat;
  logic signed [VALUE_W-1:0] om_pos;
  logic signed [VALUE_W-1:0] drive;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign om_pos   = $signed({2'b00, om_shadow});
  assign drive    = $signed(m_axis_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      om_shadow <= '0;
    end else if (cfg_valid && cfg_ready && cfg_index == REG_OUTPUT_LIMIT) begin
      om_shadow <= cfg_data[OLIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 4'(in_beat) - 4'(out_beat);
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> inflight != 4'd0)
    else $error("result beat without an accepted input beat");

  a_drive_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> drive <= om_pos && drive >= -om_pos)
    else $error("drive outside the output limit");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> drive == om_pos || drive == -om_pos)
    else $error("saturated drive not at the limit");

endmodule

bind pid_stage_with_wrap_and_limits pidw_checker u_pidw_checker (.*);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the PID stage. Input beats are queued by the stimulus
// process and presented by a burst driver. Every accepted beat runs through
// a local model of the control law, and the model's drive value is queued.
// A monitor compares every result beat with the oldest queued drive value.
module tb_top;
  import pidw_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 7;
  localparam int CYCLE_LIMIT = 400000;

  // The mode code that the package leaves unnamed acts as the plain mode.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  // No register sits at this index, so a write to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  localparam logic signed [63:0] VAL_MAX = 64'sd2147483647;
  localparam logic signed [63:0] VAL_MIN = -64'sd2147483648;
  localparam logic signed [63:0] ONE_UNIT = 64'sd1 <<< FRAC;
  localparam logic signed [127:0] TERM_CAP = 128'sd1 <<< CAP_LOG2;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic [VALUE_W-1:0] drive;
    logic               clamped;
    logic               integrating;
  } drive_result_t;

  logic clk;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [2*VALUE_W-1:0]   s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [VALUE_W-1:0]     m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]      cfg_data = '0;

  pid_stage_with_wrap_and_limits dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Model copy of the register file and of the loop state.
  logic signed [31:0]    gain_p, gain_i, gain_d;
  logic [BAND_W-1:0]     band_lim;
  logic [ILIM_W-1:0]     integ_cap;
  logic [OLIM_W-1:0]     drive_cap;
  logic [MODE_W-1:0]     loop_sel;
  logic signed [63:0]    last_err, integ_acc;

  // Beats waiting for the driver ({measured, setpoint}) and drive values
  // waiting for the monitor.
  logic [2*VALUE_W-1:0]  pending_beats[$];
  drive_result_t         expected_drives[$];
  drive_result_t         want;

  int queued_cnt = 0;
  int accepted_cnt = 0;
  int rx_beats = 0;
  int fail_count = 0;
  int cycles = 0;
  bit beat_taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [63:0] clip_value(input logic signed [63:0] v);
    if (v > VAL_MAX) return VAL_MAX;
    if (v < VAL_MIN) return VAL_MIN;
    return v;
  endfunction

  // Gain times value, fraction bits dropped with rounding toward minus
  // infinity, held within the product cap.
  function automatic logic signed [63:0] scaled_product(input logic signed [31:0] g,
                                                       input logic signed [63:0] x);
    logic signed [127:0] full;
    full = g * x;
    full = full >>> FRAC;
    if (full > TERM_CAP) full = TERM_CAP;
    if (full < -TERM_CAP) full = -TERM_CAP;
    return full[63:0];
  endfunction

  function automatic void store_setting(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [31:0] data);
    case (idx)
      REG_PROP_GAIN:    gain_p = data;
      REG_INTEG_GAIN:   gain_i = data;
      REG_DERIV_GAIN:   gain_d = data;
      REG_ERROR_BAND:   band_lim = data[BAND_W-1:0];
      REG_INTEG_LIMIT:  integ_cap = data[ILIM_W-1:0];
      REG_OUTPUT_LIMIT: drive_cap = data[OLIM_W-1:0];
      REG_LOOP_MODE:    loop_sel = data[MODE_W-1:0];
      default: ;
    endcase
  endfunction

  // One control tick of the model: updates the loop state and queues the
  // drive value that the block must return for this beat.
  function automatic void pid_tick(input logic [2*VALUE_W-1:0] beat);
    logic signed [63:0] goal, now, lim, err, p_term, d_term, band, imax, total;
    drive_result_t r;
    goal = $signed(beat[31:0]);
    now  = $signed(beat[63:32]);
    lim  = {34'd0, drive_cap};
    band = {33'd0, band_lim};
    imax = {33'd0, integ_cap};

    // Current and speed loops: pull a setpoint beyond the limit one unit inside it.
    if (loop_sel == MODE_CLAMP) begin
      if (goal > lim) goal = lim - ONE_UNIT;
      else if (goal < -lim) goal = -lim + ONE_UNIT;
    end
    err = goal - now;
    // Angle loop: take the shorter way round a period of twice the limit.
    if (loop_sel == MODE_WRAP) begin
      if (err > 0 && 2 * lim - err < err) err = err - 2 * lim;
      else if (err < 0 && 2 * lim + err < -err) err = err + 2 * lim;
    end
    err = clip_value(err);

    p_term = scaled_product(gain_p, err);
    d_term = scaled_product(gain_d, err - last_err);
    last_err = err;

    r.integrating = (err < band) && (err > -band);
    if (r.integrating) begin
      if (integ_acc < -imax) integ_acc = -imax;
      else if (integ_acc > imax) integ_acc = imax;
      else integ_acc = clip_value(integ_acc + scaled_product(gain_i, err));
    end else begin
      integ_acc = 0;
    end

    total = p_term + integ_acc + d_term;
    r.clamped = 1'b0;
    if (total > lim) begin
      total = lim;
      r.clamped = 1'b1;
    end else if (total < -lim) begin
      total = -lim;
      r.clamped = 1'b1;
    end
    r.drive = total[31:0];
    expected_drives.push_back(r);
  endfunction

  // Input side: note accepted beats and run them through the model.
  always @(posedge clk) begin
    beat_taken = !rst && s_axis_tvalid && s_axis_tready;
    if (beat_taken) begin
      pid_tick(s_axis_tdata);
      accepted_cnt++;
    end
  end

  // Burst driver. A presented beat is held until it is taken; after each
  // burst of random length there is usually a short gap, sometimes none.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || beat_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_beats.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. Ready follows a 16-bit pattern that is redrawn now and then
  // (all ones in a quarter of the draws). Twice in the run, while the driver
  // still has plenty queued, ready is held low for a long stretch so the
  // pipeline fills and the input side has to stall.
  logic [15:0] stall_pat = 16'hFFFF;
  logic [3:0]  pat_pos = '0;
  int pat_age = 0;
  int hold_left = 0;
  int holds_done = 0;
  int next_hold_at = 60;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!rst && holds_done < 2 && rx_beats >= next_hold_at &&
                 pending_beats.size() > 30) begin
      hold_left = 80;
      holds_done++;
      next_hold_at = rx_beats + 200;
      m_axis_tready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        pat_age = 48;
      end
      pat_age--;
      m_axis_tready <= stall_pat[pat_pos];
      pat_pos <= pat_pos + 4'd1;
    end
  end

  // Output side: compare every result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      rx_beats++;
      if (expected_drives.size() == 0) begin
        $error("result beat with nothing expected: drive %0d", $signed(m_axis_tdata));
        fail_count++;
      end else begin
        want = expected_drives.pop_front();
        if (m_axis_tdata !== want.drive) begin
          $error("drive mismatch: expected %0d, got %0d",
                 $signed(want.drive), $signed(m_axis_tdata));
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.clamped) begin
          $error("drive_saturated mismatch: expected %0b, got %0b",
                 want.clamped, m_axis_tuser[0]);
          fail_count++;
        end
        if (m_axis_tuser[1] !== want.integrating) begin
          $error("integ_active mismatch: expected %0b, got %0b",
                 want.integrating, m_axis_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    store_setting(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(input logic [31:0] kp, input logic [31:0] ki, input logic [31:0] kd,
                         input logic [31:0] band, input logic [31:0] imax,
                         input logic [31:0] lim, input logic [31:0] mode);
    cfg_write(REG_PROP_GAIN, kp);
    cfg_write(REG_INTEG_GAIN, ki);
    cfg_write(REG_DERIV_GAIN, kd);
    cfg_write(REG_ERROR_BAND, band);
    cfg_write(REG_INTEG_LIMIT, imax);
    cfg_write(REG_OUTPUT_LIMIT, lim);
    cfg_write(REG_LOOP_MODE, mode);
  endtask

  function automatic logic [31:0] fx(input int whole);
    return 32'(whole) << FRAC;
  endfunction

  function automatic void queue_tick(input logic [31:0] setpoint, input logic [31:0] measured);
    pending_beats.push_back({measured, setpoint});
    queued_cnt++;
  endfunction

  // Wait until every queued beat went in and every result came out, then let
  // the pipeline settle before touching the registers.
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || expected_drives.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return ($urandom_range(0, 1) == 0) ? POS_MAX : NEG_MAX;
      1: return $urandom;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_drive_limit();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(32'h0001_0000, 32'h0190_0000);
    endcase
  endfunction

  // Four beats in ten keep the measurement close to the setpoint so the error
  // lands in and around the integration band; others go near the drive limit
  // (setpoint clamp, angle fold), to the ends of the range or to random values.
  task automatic queue_random_ticks(input int count);
    logic [31:0] sp, ms, lim, near;
    for (int k = 0; k < count; k++) begin
      lim = {2'b00, drive_cap};
      near = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      case ($urandom_range(0, 9))
        0, 1: begin
          sp = $urandom;
          ms = $urandom;
        end
        2, 3, 4, 5: begin
          sp = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
          if (lim != 0 && $urandom_range(0, 1) == 0) sp = $urandom_range(0, lim) - lim / 2;
          ms = sp - near;
        end
        6, 7: begin
          sp = ($urandom_range(0, 1) == 0) ? lim + near : -lim + near;
          ms = ($urandom_range(0, 1) == 0) ? near : -sp + near;
        end
        8: begin
          sp = ($urandom_range(0, 2) == 0) ? POS_MAX : ($urandom_range(0, 1) ? NEG_MAX : 32'h0);
          ms = ($urandom_range(0, 2) == 0) ? POS_MAX : ($urandom_range(0, 1) ? NEG_MAX : near);
        end
        default: begin
          sp = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
          ms = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        end
      endcase
      queue_tick(sp, ms);
    end
  endtask

  initial begin
    gain_p = '0;
    gain_i = '0;
    gain_d = '0;
    band_lim = '0;
    integ_cap = '0;
    drive_cap = '0;
    loop_sel = MODE_CLAMP;
    last_err = 0;
    integ_acc = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Setpoint clamp with the widest drive limit: beyond either bound,
    // exactly on a bound, and the ends of the measurement range.
    set_all(fx(1), 32'h0000_8000, 32'h0000_4000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'h3FFF_FFFF, {30'd0, MODE_CLAMP});
    queue_tick(32'h0, 32'h0);
    queue_tick(POS_MAX, 32'h0);
    queue_tick(NEG_MAX, 32'h0);
    queue_tick(32'h3FFF_FFFF, 32'h0);
    queue_tick(32'hC000_0001, 32'h0);
    queue_tick(32'h0, POS_MAX);
    queue_tick(32'h0, NEG_MAX);
    wait_idle();

    // Angle loop over a 360 unit period: folds both ways, a short error
    // that stays, the integral clamped from above and from below, and an
    // error sitting exactly on the band edge.
    set_all(fx(1), fx(1), 32'h0, fx(10), fx(2), fx(180), {30'd0, MODE_WRAP});
    queue_tick(fx(170), fx(-170));
    queue_tick(fx(-170), fx(170));
    queue_tick(fx(10), fx(-10));
    queue_tick(fx(5), 32'h0);
    queue_tick(fx(5), 32'h0);
    queue_tick(fx(5), 32'h0);
    queue_tick(fx(-5), 32'h0);
    queue_tick(fx(-5), 32'h0);
    queue_tick(fx(-5), 32'h0);
    queue_tick(fx(10), 32'h0);
    wait_idle();

    // Plain mode with extreme gains: the error saturates at both ends.
    set_all(POS_MAX, NEG_MAX, NEG_MAX, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
            {30'd0, MODE_PLAIN});
    queue_tick(POS_MAX, NEG_MAX);
    queue_tick(NEG_MAX, POS_MAX);
    queue_tick(NEG_MAX, NEG_MAX);
    wait_idle();

    // The spare mode code acts as plain; the spare index holds nothing.
    cfg_write(REG_LOOP_MODE, {30'd0, MODE_SPARE});
    cfg_write(REG_SPARE, $urandom);
    queue_tick(fx(1000), 32'h0);
    queue_tick(32'h0, fx(1000));
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      set_all(pick_gain(), pick_gain(), pick_gain(), pick_bound(), pick_bound(),
              pick_drive_limit(), 32'($urandom_range(0, 3)) | ($urandom & 32'hFFFF_FFFC));
      if (ph == 3) cfg_write(REG_SPARE, $urandom);
      queue_random_ticks($urandom_range(60, 76));
      wait_idle();
    end

    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/pidw_pkg.sv
design/pidw_mul.sv
design/pid_stage_with_wrap_and_limits.sv
design/pidw_checker.sv
bench/tb_top.sv
